// File: hdl/sha_pkg.sv
// SHA-256 hash core package: transaction types, constants and round functions.
// Used by every module of the hash core; depends on nothing.
`default_nettype none
package sha_pkg;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // engine states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } eng_state_type;

   localparam logic [255:0] InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

endpackage
`default_nettype wire

// File: hdl/sha_front.sv
// SHA-256 front end: packs message bytes into 512-bit blocks, builds padding.
// Depends on sha_pkg. Hands finished blocks to the engine as one job each.
`default_nettype none
module sha_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sha_pkg::req_type   req_data,
   input  wire logic               req_push,
   output logic                    req_full,
   output logic                    job_valid,
   output logic [511:0]            job_block,
   output logic                    job_final,
   input  wire logic               job_ready
);

   logic [511:0] blk_ff, blk_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   logic         pend_ff, pend_in;       // second (length) block still to send
   logic         padblk_ff, padblk_in;   // pad+length block still to send
   logic         jv_ff, jv_in;
   logic         jf_ff, jf_in;
   logic [511:0] jb_ff, jb_in;
   logic         take;

   // the front stalls while a job waits or a trailing block is still due
   assign req_full = jv_ff | pend_ff | padblk_ff;
   assign take     = req_push & ~req_full;

   always_comb begin
      logic [511:0] b;
      logic [5:0]   f;
      logic [63:0]  l;
      blk_in  = blk_ff;
      fill_in = fill_ff;
      len_in  = len_ff;
      pend_in = pend_ff;
      jv_in   = jv_ff & ~job_ready;
      jf_in   = jf_ff;
      jb_in   = jb_ff;
      b = blk_ff;
      f = fill_ff;
      l = len_ff;
      if (pend_ff && !jv_ff) begin
         // length-only block after overflowing padding
         jb_in   = {448'd0, len_ff};
         jv_in   = 1'b1;
         jf_in   = 1'b1;
         pend_in = 1'b0;
         len_in  = '0;
      end else if (take) begin
         if (req_data.byte_valid) begin
            b[511 - 8*f -: 8] = req_data.data_byte;
            l = l + 64'd8;
            f = f + 6'd1;
            if (f == 6'd0 && !req_data.last) begin
               jb_in = b;
               jv_in = 1'b1;
               jf_in = 1'b0;
            end
         end
         if (req_data.last) begin
            if (req_data.byte_valid && f == 6'd0) begin
               // full data block plus padding: data now, pad+len after
               // (handled as block then pad+len block starting at 0)
               jb_in   = b;
               jv_in   = 1'b1;
               jf_in   = 1'b0;
               b       = '0;
               b[511]  = 1'b1;
               blk_in  = b;
               fill_in = 6'd1;
               len_in  = l;
               pend_in = 1'b0;
            end else begin
               b[511 - 8*f -: 8] = sha_pkg::PadByte;
               for (int i = 0; i < 64; i++)
                  if (6'(i) > f) b[511 - 8*i -: 8] = 8'd0;
               if (f < sha_pkg::LenStart) begin
                  b[63:0] = l;
                  jb_in   = b;
                  jv_in   = 1'b1;
                  jf_in   = 1'b1;
                  len_in  = '0;
               end else begin
                  jb_in   = b;
                  jv_in   = 1'b1;
                  jf_in   = 1'b0;
                  pend_in = 1'b1;
                  len_in  = l;
               end
               blk_in  = '0;
               fill_in = '0;
            end
         end else begin
            blk_in  = b;
            fill_in = f;
            len_in  = l;
         end
      end
   end

   // a "pad started" block of a full message: finish it as a final job
   always_comb begin
      padblk_in = padblk_ff;
      if (take && req_data.last && req_data.byte_valid && fill_ff == 6'd63)
         padblk_in = 1'b1;
      else if (padblk_ff && !jv_ff)
         padblk_in = 1'b0;
   end

   logic [511:0] jb_fin;
   logic         jv_fin, jf_fin;
   logic [511:0] blk_fin;
   logic [5:0]   fill_fin;
   logic [63:0]  len_fin;
   always_comb begin
      jb_fin = jb_in; jv_fin = jv_in; jf_fin = jf_in;
      blk_fin = blk_in; fill_fin = fill_in; len_fin = len_in;
      if (padblk_ff && !jv_ff) begin
         jb_fin  = {1'b1, 447'd0, len_ff};
         jv_fin  = 1'b1;
         jf_fin  = 1'b1;
         blk_fin = '0;
         fill_fin = '0;
         len_fin = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         len_ff    <= '0;
         pend_ff   <= 1'b0;
         jv_ff     <= 1'b0;
         padblk_ff <= 1'b0;
         blk_ff    <= '0;
      end else begin
         fill_ff   <= fill_fin;
         len_ff    <= len_fin;
         pend_ff   <= pend_in;
         jv_ff     <= jv_fin;
         padblk_ff <= padblk_in;
         blk_ff    <= blk_fin;
      end
      jb_ff <= jb_fin;
      jf_ff <= jf_fin;
   end

   assign job_valid = jv_ff;
   assign job_block = jb_ff;
   assign job_final = jf_ff;

   // the length block and the pad+length block are never pending together
   assert property (@(posedge clock) disable iff (reset) pend_ff |-> !padblk_ff)
      else $error("two trailing blocks pending");
   assert property (@(posedge clock) disable iff (reset) (jv_ff && !job_ready) |=> jv_ff)
      else $error("job dropped");
   assert property (@(posedge clock) disable iff (reset) take |-> !jv_ff)
      else $error("byte taken while job waiting");

endmodule
`default_nettype wire

// File: hdl/sha_engine.sv
// SHA-256 compression engine: one round per cycle, 16-word rolling schedule.
// Depends on sha_pkg. Takes block jobs, emits eight digest words after a final job.
`default_nettype none
module sha_engine #(
   parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire logic [511:0]     job_block,
   input  wire logic             job_final,
   output logic                  job_ready,
   output sha_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   sha_pkg::eng_state_type state_ff, state_in;
   logic [511:0] w_ff, w_in;
   logic [255:0] h_ff, h_in, v_ff, v_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         fin_ff, fin_in;
   logic [2:0]   oidx_ff, oidx_in;

   // result queue
   sha_pkg::rsp_type q_mem [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          q_push, q_pop, q_full;

   assign q_full    = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign q_pop     = rsp_pop & ~rsp_empty;
   assign rsp_data  = q_mem[rp_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_LOAD:  if (job_valid) state_in = sha_pkg::ST_ROUND;
         sha_pkg::ST_ROUND: if (rnd_ff == 6'd63) state_in = sha_pkg::ST_FOLD;
         sha_pkg::ST_FOLD:  state_in = fin_ff ? sha_pkg::ST_EMIT : sha_pkg::ST_LOAD;
         sha_pkg::ST_EMIT:  if (!q_full && oidx_ff == 3'd7) state_in = sha_pkg::ST_LOAD;
         default:           state_in = sha_pkg::ST_LOAD;
      endcase
   end

   // datapath
   always_comb begin
      logic [31:0] a, e, t1, t2, s0, s1, wn;
      job_ready = 1'b0;
      q_push    = 1'b0;
      w_in = w_ff; h_in = h_ff; v_in = v_ff;
      rnd_in = rnd_ff; fin_in = fin_ff; oidx_in = oidx_ff;
      a = v_ff[255:224]; e = v_ff[127:96];
      t1 = v_ff[31:0]
         + (sha_pkg::ror(e,6) ^ sha_pkg::ror(e,11) ^ sha_pkg::ror(e,25))
         + ((e & v_ff[95:64]) ^ (~e & v_ff[63:32]))
         + sha_pkg::round_k(rnd_ff) + w_ff[511:480];
      t2 = (sha_pkg::ror(a,2) ^ sha_pkg::ror(a,13) ^ sha_pkg::ror(a,22))
         + ((a & v_ff[223:192]) ^ (a & v_ff[191:160]) ^ (v_ff[223:192] & v_ff[191:160]));
      s0 = sha_pkg::ror(w_ff[479:448],7) ^ sha_pkg::ror(w_ff[479:448],18)
         ^ (w_ff[479:448] >> 3);
      s1 = sha_pkg::ror(w_ff[63:32],17) ^ sha_pkg::ror(w_ff[63:32],19)
         ^ (w_ff[63:32] >> 10);
      wn = w_ff[511:480] + s0 + w_ff[223:192] + s1;
      unique case (state_ff)
         sha_pkg::ST_LOAD: begin
            job_ready = 1'b1;
            if (job_valid) begin
               w_in = job_block; v_in = h_ff; fin_in = job_final; rnd_in = '0;
            end
         end
         sha_pkg::ST_ROUND: begin
            v_in = {t1 + t2, v_ff[255:160], v_ff[159:128] + t1, v_ff[127:32]};
            w_in = {w_ff[479:0], wn};
            rnd_in = rnd_ff + 6'd1;
         end
         sha_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++)
               h_in[32*i +: 32] = h_ff[32*i +: 32] + v_ff[32*i +: 32];
            oidx_in = '0;
         end
         sha_pkg::ST_EMIT: begin
            if (!q_full) begin
               q_push = 1'b1;
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) h_in = sha_pkg::InitHash;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_LOAD;
         h_ff     <= sha_pkg::InitHash;
         rnd_ff   <= '0;
         oidx_ff  <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         if (q_push) wp_ff <= (32'(wp_ff) == QUEUE_DEPTH-1) ? '0 : wp_ff + 1'b1;
         if (q_pop)  rp_ff <= (32'(rp_ff) == QUEUE_DEPTH-1) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(q_push) - (AW+1)'(q_pop);
      end
      w_ff <= w_in; v_ff <= v_in; fin_ff <= fin_in;
      if (q_push)
         q_mem[wp_ff] <= '{digest_word: h_ff[255 - 32*oidx_ff -: 32],
                           word_index: oidx_ff, last_word: (oidx_ff == 3'd7)};
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_ROUND && rnd_ff == 6'd63) |=> state_ff == sha_pkg::ST_FOLD)
      else $error("round count off");
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      job_ready |-> state_ff == sha_pkg::ST_LOAD)
      else $error("job taken mid-block");

endmodule
`default_nettype wire

// File: hdl/sha256_hash_core.sv
// SHA-256 hash core top level: byte front end feeding a round engine.
// Depends on sha_pkg, sha_front and sha_engine.
//
// Push one byte per transaction; last ends the message and, after padding,
// eight digest words come out of the result queue, index 0 first. Bytes are
// taken one per cycle while a block fills, with a stall whenever a full block
// is handed over or waits for the engine. The round engine works on a block
// (load, 64 rounds, fold) while the next block fills. The message ends in one
// or two padding blocks; the digest words then pass through the four-entry
// (default) result queue, and the engine waits while the queue is full.
`default_nettype none
module sha256_hash_core #(
   parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sha_pkg::req_type req_data,
   input  wire logic             req_push,
   output logic                  req_full,
   output sha_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);

   logic         job_valid, job_final, job_ready;
   logic [511:0] job_block;

   sha_front u_front (
      .clock, .reset, .req_data, .req_push, .req_full,
      .job_valid, .job_block, .job_final, .job_ready);

   sha_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock, .reset, .job_valid, .job_block, .job_final, .job_ready,
      .rsp_data, .rsp_empty, .rsp_pop);

endmodule
`default_nettype wire
